### rtl/great_circle_distance_top_assert.svh
// assertion macros for the great-circle distance block
`ifndef GREAT_CIRCLE_DISTANCE_TOP_ASSERT_SVH
`define GREAT_CIRCLE_DISTANCE_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define GCD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gcd check failed");
`define GCD_ASSERT_AFTER(label, clk, rst, ante, dly, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error("gcd latency check failed");
`else
`define GCD_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define GCD_ASSERT_AFTER(label, clk, rst, ante, dly, cons)
`endif
`endif

### rtl/gcd_pkg.sv
// shared types, constants and helper functions of the great-circle distance block
package gcd_pkg;

   localparam int CORDIC_STAGES_DEF = 32;
   localparam int SQRT_STEPS = 31;
   localparam int XY_W = 34;
   localparam int Z_W = 33;
   localparam int UNITS_W = 33;
   localparam int RAD_W = 61;
   localparam int ROOT_W = 31;
   localparam int DIST_W = 35;

   localparam logic [63:0] PI_Q29 = 64'd1686629713;
   localparam logic signed [Z_W-1:0] PI_Z = 33'sd1686629713;
   localparam logic signed [Z_W-1:0] HALF_PI_Z = 33'sd843314856;
   localparam logic signed [XY_W-1:0] GAIN_INV_Q30 = 34'sd652032874;
   localparam logic [63:0] FULL_DIV = 64'd1800000000;
   localparam logic [63:0] HALF_DIV = 64'd3600000000;
   localparam logic [ROOT_W-1:0] ONE_Q30 = 31'd1073741824;
   localparam logic [32:0] RADIUS_MM = 33'd6371000000;
   localparam logic [63:0] DIST_ROUND = 64'd134217728;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } cordic_type;

   typedef struct packed {
      logic [RAD_W-1:0] rem;
      logic [RAD_W-1:0] root;
   } sqrt_type;

   function automatic logic signed [Z_W-1:0] stage_angle(input int unsigned i);
      logic signed [Z_W-1:0] ang;
      case (i)
         0: ang = 33'sd421657428;
         1: ang = 33'sd248918915;
         2: ang = 33'sd131521918;
         3: ang = 33'sd66762579;
         4: ang = 33'sd33510843;
         5: ang = 33'sd16771758;
         6: ang = 33'sd8387925;
         7: ang = 33'sd4194219;
         8: ang = 33'sd2097141;
         9: ang = 33'sd1048575;
         default: ang = (i <= 29) ? $signed(Z_W'(64'd1 << (29 - i))) : '0;
      endcase
      return ang;
   endfunction

   // q30 product: magnitudes multiplied, rounded half up, sign put back
   function automatic logic signed [XY_W-1:0] mul_q30(input logic signed [XY_W-1:0] a,
                                                      input logic signed [XY_W-1:0] b);
      logic [XY_W-1:0] fa, fb;
      logic [31:0] ma, mb;
      logic [63:0] p;
      logic [XY_W-1:0] r;
      fa = a[XY_W-1] ? XY_W'(-a) : XY_W'(a);
      fb = b[XY_W-1] ? XY_W'(-b) : XY_W'(b);
      ma = fa[31:0];
      mb = fb[31:0];
      p = 64'(ma) * 64'(mb);
      r = XY_W'((p + 64'd536870912) >> 30);
      return (a[XY_W-1] ^ b[XY_W-1]) ? -$signed(r) : $signed(r);
   endfunction

endpackage

### rtl/gcd_to_rad.sv
// conversion of 1e-7 degree units to a q3.29 radian angle, three register stages
module gcd_to_rad #(
   parameter logic [63:0] DIVISOR = gcd_pkg::FULL_DIV
) (
   input  logic                                 clock,
   input  logic signed [gcd_pkg::UNITS_W-1:0]   units,
   output logic signed [gcd_pkg::Z_W-1:0]       angle
);

   localparam logic [63:0] RECIP = (gcd_pkg::PI_Q29 << 32) / DIVISOR;
   localparam logic [63:0] HALF = DIVISOR >> 1;
   localparam logic [63:0] TWICE = DIVISOR << 1;

   logic [gcd_pkg::UNITS_W-1:0] mag_full;
   logic [31:0] mag;
   logic [63:0] qp_ff, qp_in, p_ff, p_in, p2_ff, qd_ff, qd_in, r;
   logic [31:0] q0_ff, q;
   logic neg_ff, neg2_ff;
   logic signed [gcd_pkg::Z_W-1:0] angle_ff, angle_in;

   always_comb begin
      mag_full = units[gcd_pkg::UNITS_W-1] ? gcd_pkg::UNITS_W'(-units)
                                           : gcd_pkg::UNITS_W'(units);
      mag = mag_full[31:0];
      // estimate from the reciprocal, then exact remainder fix-up
      qp_in = 64'(mag) * 64'(RECIP[31:0]);
      p_in = 64'(mag) * 64'(gcd_pkg::PI_Q29[31:0]) + HALF;
      qd_in = 64'(qp_ff[63:32]) * 64'(DIVISOR[31:0]);
      r = p2_ff - qd_ff;
      if (r >= TWICE) begin
         q = q0_ff + 32'd2;
      end else if (r >= DIVISOR) begin
         q = q0_ff + 32'd1;
      end else begin
         q = q0_ff;
      end
      angle_in = neg2_ff ? -$signed(gcd_pkg::Z_W'(q)) : $signed(gcd_pkg::Z_W'(q));
   end

   always_ff @(posedge clock) begin
      qp_ff <= qp_in;
      p_ff <= p_in;
      neg_ff <= units[gcd_pkg::UNITS_W-1];
      qd_ff <= qd_in;
      q0_ff <= qp_ff[63:32];
      p2_ff <= p_ff;
      neg2_ff <= neg_ff;
      angle_ff <= angle_in;
   end

   // neg2_ff lines up with the remainder stage
   assign angle = angle_ff;

endmodule

### rtl/gcd_cordic_cell.sv
// one cordic micro-rotation cell, rotation or vectoring mode
module gcd_cordic_cell #(
   parameter int STAGE     = 0,
   parameter bit VECTORING = 1'b0
) (
   input  logic                clock,
   input  gcd_pkg::cordic_type src,
   output gcd_pkg::cordic_type dst
);

   localparam logic signed [gcd_pkg::Z_W-1:0] ANGLE = gcd_pkg::stage_angle(STAGE);

   logic signed [gcd_pkg::XY_W-1:0] x_sh, y_sh;
   logic pos;
   gcd_pkg::cordic_type data_ff, data_in;

   always_comb begin
      x_sh = $signed(src.x) >>> STAGE;
      y_sh = $signed(src.y) >>> STAGE;
      pos = VECTORING ? src.y[gcd_pkg::XY_W-1] : !src.z[gcd_pkg::Z_W-1];
      if (pos) begin
         data_in.x = $signed(src.x) - y_sh;
         data_in.y = $signed(src.y) + x_sh;
         data_in.z = $signed(src.z) - ANGLE;
      end else begin
         data_in.x = $signed(src.x) + y_sh;
         data_in.y = $signed(src.y) - x_sh;
         data_in.z = $signed(src.z) + ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign dst = data_ff;

endmodule

### rtl/gcd_sqrt_cell.sv
// one restoring square-root digit cell
module gcd_sqrt_cell #(
   parameter int STEP = 0
) (
   input  logic              clock,
   input  gcd_pkg::sqrt_type src,
   output gcd_pkg::sqrt_type dst
);

   localparam logic [gcd_pkg::RAD_W-1:0] BIT =
      gcd_pkg::RAD_W'(64'd1 << (2 * (gcd_pkg::SQRT_STEPS - 1 - STEP)));

   logic [gcd_pkg::RAD_W:0] trial;
   gcd_pkg::sqrt_type data_ff, data_in;

   always_comb begin
      trial = {1'b0, src.root} + {1'b0, BIT};
      if ({1'b0, src.rem} >= trial) begin
         data_in.rem = src.rem - trial[gcd_pkg::RAD_W-1:0];
         data_in.root = (src.root >> 1) + BIT;
      end else begin
         data_in.rem = src.rem;
         data_in.root = src.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign dst = data_ff;

endmodule

### rtl/great_circle_distance_top.sv
// top level of the great-circle distance block: haversine distance pipeline
// Takes a pair of points (latitude and longitude in 1e-7 degree) and returns their
// great-circle distance on a 6371 km sphere in millimetres. The block is one pipeline of
// cordic, multiplier and square-root cells, so busy stays low and a new request may be
// given with start in every cycle. Each result shows on rsp_distance_mm with rsp_valid
// high for exactly one cycle, once its request has passed a rotation cordic chain, the
// 31 square-root digit cells and the vectoring cordic chain. Results come out in
// request order and cannot be held off.
`include "great_circle_distance_top_assert.svh"
module great_circle_distance_top #(
   parameter int CORDIC_STAGES = gcd_pkg::CORDIC_STAGES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [30:0]                req_start_latitude,
   input  logic signed [31:0]                req_start_longitude,
   input  logic signed [30:0]                req_end_latitude,
   input  logic signed [31:0]                req_end_longitude,
   output logic                              rsp_valid,
   output logic [gcd_pkg::DIST_W-1:0]        rsp_distance_mm
);

   localparam int LAT = 40 + 2 * CORDIC_STAGES;
   localparam int SQRT_DONE = 37 + CORDIC_STAGES;
   localparam int ROT_CHAINS = 4;
   localparam int CH_DLAT = 0;
   localparam int CH_DLON = 1;
   localparam int CH_LAT1 = 2;
   localparam int CH_LAT2 = 3;

   logic req_accept;
   logic [LAT-1:0] vld_ff, vld_in;

   logic signed [30:0] lat1_ff, lat2_ff;
   logic signed [31:0] lon1_ff, lon2_ff;
   logic signed [gcd_pkg::UNITS_W-1:0] units [ROT_CHAINS];
   logic signed [gcd_pkg::Z_W-1:0] angle [ROT_CHAINS];
   logic signed [gcd_pkg::Z_W-1:0] rot_z [ROT_CHAINS];
   logic [ROT_CHAINS-1:0] flip_now;
   logic [ROT_CHAINS-1:0] flip_ff [CORDIC_STAGES];
   gcd_pkg::cordic_type rot_chain [ROT_CHAINS][CORDIC_STAGES+1];

   logic signed [gcd_pkg::XY_W-1:0] s1, s2, c1, c2;
   logic signed [gcd_pkg::XY_W-1:0] ss1_ff, ss2_ff, cc_ff, plat_ff, plon_ff;
   logic signed [gcd_pkg::XY_W:0] hav_sum;
   logic [gcd_pkg::ROOT_W-1:0] a_ff, a_in, b_ff;

   gcd_pkg::sqrt_type sqa_chain [gcd_pkg::SQRT_STEPS+1];
   gcd_pkg::sqrt_type sqb_chain [gcd_pkg::SQRT_STEPS+1];
   logic [gcd_pkg::ROOT_W-1:0] root_a, root_b;

   gcd_pkg::cordic_type vec_chain [CORDIC_STAGES+1];
   logic [31:0] theta;
   logic [63:0] prod_ff, prod_in;
   logic [gcd_pkg::DIST_W-1:0] dist_ff, dist_in;

   assign busy = 1'b0;
   assign req_accept = start & !busy;

   always_comb begin
      vld_in = {vld_ff[LAT-2:0], req_accept};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      lat1_ff <= req_start_latitude;
      lon1_ff <= req_start_longitude;
      lat2_ff <= req_end_latitude;
      lon2_ff <= req_end_longitude;
   end

   assign units[CH_DLAT] = gcd_pkg::UNITS_W'(lat2_ff) - gcd_pkg::UNITS_W'(lat1_ff);
   assign units[CH_DLON] = gcd_pkg::UNITS_W'(lon2_ff) - gcd_pkg::UNITS_W'(lon1_ff);
   assign units[CH_LAT1] = gcd_pkg::UNITS_W'(lat1_ff);
   assign units[CH_LAT2] = gcd_pkg::UNITS_W'(lat2_ff);

   gcd_to_rad #(.DIVISOR(gcd_pkg::HALF_DIV)) u_rad_dlat (
      .clock(clock), .units(units[CH_DLAT]), .angle(angle[CH_DLAT]));
   gcd_to_rad #(.DIVISOR(gcd_pkg::HALF_DIV)) u_rad_dlon (
      .clock(clock), .units(units[CH_DLON]), .angle(angle[CH_DLON]));
   gcd_to_rad #(.DIVISOR(gcd_pkg::FULL_DIV)) u_rad_lat1 (
      .clock(clock), .units(units[CH_LAT1]), .angle(angle[CH_LAT1]));
   gcd_to_rad #(.DIVISOR(gcd_pkg::FULL_DIV)) u_rad_lat2 (
      .clock(clock), .units(units[CH_LAT2]), .angle(angle[CH_LAT2]));

   // fold angles beyond a quarter turn back by half a turn, negating sin and cos
   always_comb begin
      for (int k = 0; k < ROT_CHAINS; k++) begin
         if (angle[k] > gcd_pkg::HALF_PI_Z) begin
            rot_z[k] = angle[k] - gcd_pkg::PI_Z;
            flip_now[k] = 1'b1;
         end else if (angle[k] < -gcd_pkg::HALF_PI_Z) begin
            rot_z[k] = angle[k] + gcd_pkg::PI_Z;
            flip_now[k] = 1'b1;
         end else begin
            rot_z[k] = angle[k];
            flip_now[k] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      flip_ff[0] <= flip_now;
      for (int i = 1; i < CORDIC_STAGES; i++) begin
         flip_ff[i] <= flip_ff[i-1];
      end
   end

   for (genvar k = 0; k < ROT_CHAINS; k++) begin : g_rot
      assign rot_chain[k][0] = '{x: gcd_pkg::GAIN_INV_Q30, y: '0, z: rot_z[k]};
      for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
         gcd_cordic_cell #(.STAGE(i), .VECTORING(1'b0)) u_cell (
            .clock(clock), .src(rot_chain[k][i]), .dst(rot_chain[k][i+1]));
      end
   end

   always_comb begin
      s1 = flip_ff[CORDIC_STAGES-1][CH_DLAT] ? -$signed(rot_chain[CH_DLAT][CORDIC_STAGES].y)
                                             : $signed(rot_chain[CH_DLAT][CORDIC_STAGES].y);
      s2 = flip_ff[CORDIC_STAGES-1][CH_DLON] ? -$signed(rot_chain[CH_DLON][CORDIC_STAGES].y)
                                             : $signed(rot_chain[CH_DLON][CORDIC_STAGES].y);
      c1 = flip_ff[CORDIC_STAGES-1][CH_LAT1] ? -$signed(rot_chain[CH_LAT1][CORDIC_STAGES].x)
                                             : $signed(rot_chain[CH_LAT1][CORDIC_STAGES].x);
      c2 = flip_ff[CORDIC_STAGES-1][CH_LAT2] ? -$signed(rot_chain[CH_LAT2][CORDIC_STAGES].x)
                                             : $signed(rot_chain[CH_LAT2][CORDIC_STAGES].x);
      hav_sum = (gcd_pkg::XY_W+1)'(plat_ff) + (gcd_pkg::XY_W+1)'(plon_ff);
      // haversine term saturated to [0, 1]
      if (hav_sum[gcd_pkg::XY_W]) begin
         a_in = '0;
      end else if (hav_sum > $signed({4'b0, gcd_pkg::ONE_Q30})) begin
         a_in = gcd_pkg::ONE_Q30;
      end else begin
         a_in = hav_sum[gcd_pkg::ROOT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      ss1_ff <= gcd_pkg::mul_q30(s1, s1);
      ss2_ff <= gcd_pkg::mul_q30(s2, s2);
      cc_ff <= gcd_pkg::mul_q30(c1, c2);
      plat_ff <= ss1_ff;
      plon_ff <= gcd_pkg::mul_q30(ss2_ff, cc_ff);
      a_ff <= a_in;
      b_ff <= gcd_pkg::ONE_Q30 - a_in;
   end

   assign sqa_chain[0] = '{rem: {a_ff, 30'b0}, root: '0};
   assign sqb_chain[0] = '{rem: {b_ff, 30'b0}, root: '0};

   for (genvar j = 0; j < gcd_pkg::SQRT_STEPS; j++) begin : g_sqrt
      gcd_sqrt_cell #(.STEP(j)) u_sqa (
         .clock(clock), .src(sqa_chain[j]), .dst(sqa_chain[j+1]));
      gcd_sqrt_cell #(.STEP(j)) u_sqb (
         .clock(clock), .src(sqb_chain[j]), .dst(sqb_chain[j+1]));
   end

   assign root_a = sqa_chain[gcd_pkg::SQRT_STEPS].root[gcd_pkg::ROOT_W-1:0];
   assign root_b = sqb_chain[gcd_pkg::SQRT_STEPS].root[gcd_pkg::ROOT_W-1:0];

   assign vec_chain[0] = '{x: $signed(gcd_pkg::XY_W'(root_b)),
                           y: $signed(gcd_pkg::XY_W'(root_a)), z: '0};

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
      gcd_cordic_cell #(.STAGE(i), .VECTORING(1'b1)) u_cell (
         .clock(clock), .src(vec_chain[i]), .dst(vec_chain[i+1]));
   end

   always_comb begin
      // tiny negative angle clamped to zero
      theta = vec_chain[CORDIC_STAGES].z[gcd_pkg::Z_W-1] ? '0
                                                        : vec_chain[CORDIC_STAGES].z[31:0];
      prod_in = 64'(theta) * 64'(gcd_pkg::RADIUS_MM);
      dist_in = gcd_pkg::DIST_W'((prod_ff + gcd_pkg::DIST_ROUND) >> 28);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      dist_ff <= dist_in;
   end

   assign rsp_valid = vld_ff[LAT-1];
   assign rsp_distance_mm = dist_ff;

   `GCD_ASSERT_AFTER(a_req_gives_rsp, clock, reset, req_accept, LAT, rsp_valid)
   `GCD_ASSERT_IMPLY(a_rsp_had_req, clock, reset, rsp_valid, $past(req_accept, LAT))
   `GCD_ASSERT_IMPLY(a_root_bound, clock, reset, vld_ff[SQRT_DONE], (root_a <= gcd_pkg::ONE_Q30) && (root_b <= gcd_pkg::ONE_Q30))

endmodule

### tb/great_circle_distance_top_test.sv
// testbench for the great-circle distance block: table-driven and random point pairs
`timescale 1ns / 1ps
module great_circle_distance_top_test;

   localparam int STAGES = gcd_pkg::CORDIC_STAGES_DEF;
   localparam int LATENCY = 40 + 2 * STAGES;
   localparam int N_RANDOM = 1750;
   localparam longint LAT_MAX = 900000000;
   localparam longint LON_MAX = 1800000000;
   localparam longint NO_CHECK = -1;

   typedef struct {
      logic signed [30:0] lat1;
      logic signed [31:0] lon1;
      logic signed [30:0] lat2;
      logic signed [31:0] lon2;
      longint             known;
   } point_pair_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic signed [30:0]  req_start_latitude;
   logic signed [31:0]  req_start_longitude;
   logic signed [30:0]  req_end_latitude;
   logic signed [31:0]  req_end_longitude;
   logic                rsp_valid;
   logic [gcd_pkg::DIST_W-1:0] rsp_distance_mm;

   logic [gcd_pkg::DIST_W-1:0] pending_distances[$];
   int                mismatches = 0;
   bit                stimulus_done = 0;
   point_pair_type    pair_table[$];

   great_circle_distance_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_start_latitude(req_start_latitude), .req_start_longitude(req_start_longitude),
      .req_end_latitude(req_end_latitude), .req_end_longitude(req_end_longitude),
      .rsp_valid(rsp_valid), .rsp_distance_mm(rsp_distance_mm)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // arithmetic shift right, rounding toward minus infinity
   function automatic longint shift_down(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint angle_of(int i);
      longint head[10] = '{421657428, 248918915, 131521918, 66762579, 33510843,
                           16771758, 8387925, 4194219, 2097141, 1048575};
      if (i < 10) return head[i];
      if (i <= 29) return longint'(1) << (29 - i);
      return 0;
   endfunction

   function automatic longint units_to_rad(longint units, longint unsigned divisor);
      longint unsigned m, q;
      m = units < 0 ? -units : units;
      q = (m * 64'd1686629713 + divisor / 2) / divisor;
      return units < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint q30_product(longint a, longint b);
      longint unsigned p;
      longint r;
      p = longint'(a < 0 ? -a : a) * longint'(b < 0 ? -b : b);
      r = longint'((p + (64'd1 << 29)) >> 30);
      return ((a < 0) != (b < 0)) ? -r : r;
   endfunction

   task automatic rotate(input longint theta, output longint sine, output longint cosine);
      longint x, y, z, dx, dy;
      bit flip;
      x = 652032874; y = 0; z = theta; flip = 0;
      if (z > 843314856) begin
         z -= 1686629713; flip = 1;
      end else if (z < -843314856) begin
         z += 1686629713; flip = 1;
      end
      for (int i = 0; i < STAGES; i++) begin
         dx = shift_down(y, i); dy = shift_down(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= angle_of(i);
         end else begin
            x += dx; y -= dy; z += angle_of(i);
         end
      end
      sine = flip ? -y : y;
      cosine = flip ? -x : x;
   endtask

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root, bitv;
      root = 0; bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   task automatic haversine_mm(input point_pair_type p,
                               output logic [gcd_pkg::DIST_W-1:0] distance);
      longint lat1, lat2, s1, s2, c1, c2, dummy, a, b, x, y, z, dx, dy;
      longint unsigned full;
      lat1 = p.lat1; lat2 = p.lat2;
      rotate(units_to_rad(lat2 - lat1, 64'd3600000000), s1, dummy);
      rotate(units_to_rad(longint'(p.lon2) - longint'(p.lon1), 64'd3600000000), s2, dummy);
      rotate(units_to_rad(lat1, 64'd1800000000), dummy, c1);
      rotate(units_to_rad(lat2, 64'd1800000000), dummy, c2);
      a = q30_product(s1, s1) + q30_product(q30_product(s2, s2), q30_product(c1, c2));
      if (a < 0) a = 0;
      if (a > 1073741824) a = 1073741824;
      b = 1073741824 - a;
      y = int_sqrt(longint'(a) << 30);
      x = int_sqrt(longint'(b) << 30);
      z = 0;
      for (int i = 0; i < STAGES; i++) begin
         dx = shift_down(y, i); dy = shift_down(x, i);
         if (y >= 0) begin
            x += dx; y -= dy; z += angle_of(i);
         end else begin
            x -= dx; y += dy; z -= angle_of(i);
         end
      end
      if (z < 0) z = 0;
      full = (longint'(z) * 64'd6371000000 + (64'd1 << 27)) >> 28;
      distance = full[gcd_pkg::DIST_W-1:0];
   endtask

   task automatic report_mismatch(input string what);
      $display("mismatch: %s", what);
      mismatches++;
   endtask

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 140);
   endfunction

   function automatic longint rand_span(longint lim);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return $signed($urandom()) ; // any value the field allows
      if (r == 1) return $urandom_range(0, 1) ? lim : -lim;
      return longint'($urandom_range(0, 2 * lim)) - lim;
   endfunction

   function automatic point_pair_type random_pair();
      point_pair_type p;
      longint v;
      v = rand_span(LAT_MAX); p.lat1 = v[30:0];
      v = rand_span(LON_MAX); p.lon1 = v[31:0];
      if ($urandom_range(0, 3) == 0) begin
         // nearby point: small differences
         v = longint'(p.lat1) + longint'($urandom_range(0, 2000)) - 1000;
         p.lat2 = v[30:0];
         v = longint'(p.lon1) + longint'($urandom_range(0, 2000)) - 1000;
         p.lon2 = v[31:0];
      end else begin
         v = rand_span(LAT_MAX); p.lat2 = v[30:0];
         v = rand_span(LON_MAX); p.lon2 = v[31:0];
      end
      p.known = NO_CHECK;
      return p;
   endfunction

   function automatic point_pair_type row(longint a, longint b, longint c, longint d,
                                          longint k);
      point_pair_type p;
      p.lat1 = a[30:0]; p.lon1 = b[31:0]; p.lat2 = c[30:0]; p.lon2 = d[31:0]; p.known = k;
      return p;
   endfunction

   task automatic send_pair(input point_pair_type p);
      logic [gcd_pkg::DIST_W-1:0] predicted;
      req_start_latitude <= p.lat1;
      req_start_longitude <= p.lon1;
      req_end_latitude <= p.lat2;
      req_end_longitude <= p.lon2;
      start <= 1;
      do @(posedge clock); while (busy);
      haversine_mm(p, predicted);
      if (p.known != NO_CHECK && predicted != p.known[gcd_pkg::DIST_W-1:0])
         report_mismatch($sformatf("table row %0d expected, predictor gives %0d",
                                   p.known, predicted));
      pending_distances.push_back(predicted);
      @(negedge clock);
   endtask

   // result checking
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_distances.size() == 0) begin
            report_mismatch($sformatf("unexpected distance %0d", rsp_distance_mm));
         end else begin
            if (rsp_distance_mm !== pending_distances[0])
               report_mismatch($sformatf("distance %0d, expected %0d",
                                         rsp_distance_mm, pending_distances[0]));
            void'(pending_distances.pop_front());
         end
      end
   end

   initial begin
      int g;
      reset = 1; start = 0;
      req_start_latitude = '0; req_start_longitude = '0;
      req_end_latitude = '0; req_end_longitude = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed table: corners and open cases, every row checked by the predictor
      pair_table.push_back(row(0, 0, 0, 0, NO_CHECK));
      pair_table.push_back(row(LAT_MAX, LON_MAX, LAT_MAX, LON_MAX, NO_CHECK));
      pair_table.push_back(row(-LAT_MAX, -LON_MAX, -LAT_MAX, -LON_MAX, NO_CHECK));
      pair_table.push_back(row(LAT_MAX, 0, -LAT_MAX, 0, NO_CHECK));
      pair_table.push_back(row(0, 0, 0, LON_MAX, NO_CHECK));
      pair_table.push_back(row(0, -LON_MAX, 0, LON_MAX, NO_CHECK));
      pair_table.push_back(row(0, 0, 0, 1, NO_CHECK));
      pair_table.push_back(row(0, 0, 1, 0, NO_CHECK));
      pair_table.push_back(row(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX, NO_CHECK));
      pair_table.push_back(row(450000000, 0, -450000000, LON_MAX, NO_CHECK));
      // latitudes beyond the pole and longitudes beyond the date line
      pair_table.push_back(row(-(longint'(1) << 30), 0, (longint'(1) << 30) - 1, 0, NO_CHECK));
      pair_table.push_back(row((longint'(1) << 30) - 1, -(longint'(1) << 31),
                               -(longint'(1) << 30), (longint'(1) << 31) - 1, NO_CHECK));
      pair_table.push_back(row(0, 0, 0, (longint'(1) << 31) - 1, NO_CHECK));
      pair_table.push_back(row(LAT_MAX, 1234567, LAT_MAX, -987654321, NO_CHECK));
      pair_table.push_back(row(515000000, -1270000, 488566000, 23522000, NO_CHECK));
      pair_table.push_back(row(-1, -1, 1, 1, NO_CHECK));
      foreach (pair_table[i]) send_pair(pair_table[i]);

      for (int n = 0; n < N_RANDOM; n++) begin
         g = ($urandom_range(0, 3) == 0) ? 0 : gap_length();
         if (g > 0) begin
            start <= 0;
            repeat (g) @(negedge clock);
         end
         send_pair(random_pair());
      end
      start <= 0;
      stimulus_done = 1;
   end

   initial begin
      wait (stimulus_done);
      while (pending_distances.size() != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end
endmodule

### files.f
+incdir+rtl
rtl/gcd_pkg.sv
rtl/gcd_to_rad.sv
rtl/gcd_cordic_cell.sv
rtl/gcd_sqrt_cell.sv
rtl/great_circle_distance_top.sv
tb/great_circle_distance_top_test.sv
